@@ rtl/ile_pkg.sv @@
package ile_pkg;

  // list geometry
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  // port field widths
  localparam int ACT_W    = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int FPOS_W   = 6;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 2;

  // internal count and compare widths
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // operation shared by every cell in the row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE,
    CELL_DROP
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] len;
    word_t            val;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ERASE
  } state_t;

endpackage

@@ rtl/ile_cell.sv @@
module ile_cell (
  input  logic                       clk,
  input  ile_pkg::cell_ctrl_t        ctrl,
  input  logic [ile_pkg::CMP_W-1:0]  idx,
  input  ile_pkg::word_t             prev_d,
  input  ile_pkg::word_t             next_d,
  input  ile_pkg::word_t             head_d,
  output ile_pkg::word_t             data
);

  ile_pkg::word_t             data_r;
  ile_pkg::word_t             data_nxt;
  logic [ile_pkg::CMP_W-1:0]  idx_p1;

  assign idx_p1 = idx + ile_pkg::CMP_W'(1);

  // pick the new entry from the neighbors, the head or the new value
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      ile_pkg::CELL_INSERT: begin
        if (idx == ctrl.pos) begin
          data_nxt = ctrl.val;
        end else if (idx > ctrl.pos) begin
          data_nxt = prev_d;
        end
      end
      ile_pkg::CELL_REMOVE: begin
        if (idx >= ctrl.pos) begin
          data_nxt = next_d;
        end
      end
      ile_pkg::CELL_ROTATE: begin
        if (idx_p1 < ctrl.len) begin
          data_nxt = next_d;
        end else if (idx_p1 == ctrl.len) begin
          data_nxt = head_d;
        end
      end
      ile_pkg::CELL_DROP: begin
        if (idx_p1 < ctrl.len) begin
          data_nxt = next_d;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

@@ rtl/indexed_list_engine.sv @@
// Ordered list engine holding up to CAPACITY signed words in a row of cells.
// Requests arrive on in_valid/in_ready (action, position, item_value); each
// request gives exactly one result on out_valid/out_ready.
// Insert, remove, clear, unknown actions, empty-list search and every rejected
// request finish in the accept cycle: the result is valid on the next cycle.
// Search and read walk the list through the head cell by rotating the chain
// one entry per cycle, one full turn of the list before the result.
// Erase all equal takes two passes, one to fetch the entry at the position
// and one to compact the list.
// Both walks are paced by the single head cell that every entry passes.
// One request is in flight at a time; in_ready is high when the engine is
// idle and the result register is empty or being emptied in that cycle, so
// requests that finish at once can follow one per cycle while out_ready is high.
// While out_ready is low the result is held and no new request is taken.
// Reset (rst_n low, synchronous) empties the list and drops any result;
// entry contents are not cleared, only positions below the length count are read.
module indexed_list_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ile_pkg::ACT_W-1:0]     in_action,
  input  logic [ile_pkg::POS_W-1:0]     in_position,
  input  logic signed [ile_pkg::VAL_W-1:0] in_item_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ile_pkg::VAL_W-1:0] out_read_value,
  output logic                          out_found,
  output logic [ile_pkg::FPOS_W-1:0]    out_found_position,
  output logic [ile_pkg::LEN_W-1:0]     out_list_length,
  output logic [ile_pkg::STATUS_W-1:0]  out_status
);

  ile_pkg::state_t              state_r, state_nxt;
  logic [ile_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [ile_pkg::CNT_W-1:0]    len_r, len_nxt;
  logic [ile_pkg::CNT_W-1:0]    step_r, step_nxt;
  logic [ile_pkg::ACT_W-1:0]    op_r, op_nxt;
  logic [ile_pkg::CMP_W-1:0]    pos_r, pos_nxt;
  ile_pkg::word_t               val_r, val_nxt;
  ile_pkg::word_t               saved_r, saved_nxt;
  logic                         fnd_r, fnd_nxt;
  logic [ile_pkg::FPOS_W-1:0]   fpos_r, fpos_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic signed [ile_pkg::VAL_W-1:0] out_read_value_r, out_read_value_nxt;
  logic                             out_found_r, out_found_nxt;
  logic [ile_pkg::FPOS_W-1:0]       out_found_position_r, out_found_position_nxt;
  logic [ile_pkg::LEN_W-1:0]        out_list_length_r, out_list_length_nxt;
  logic [ile_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;

  ile_pkg::cell_ctrl_t          ctrl;
  ile_pkg::word_t               cell_data [ile_pkg::CAPACITY];
  ile_pkg::word_t               head;
  ile_pkg::word_t               in_word;
  logic [ile_pkg::CMP_W-1:0]    in_pos_ext;
  logic [ile_pkg::CMP_W-1:0]    count_ext;
  logic [ile_pkg::CMP_W-1:0]    step_ext;
  logic                         in_fire;
  logic                         last_step;

  assign in_word    = ile_pkg::DATA_WIDTH'(in_item_value);
  assign in_pos_ext = ile_pkg::CMP_W'(in_position);
  assign count_ext  = ile_pkg::CMP_W'(count_r);
  assign step_ext   = ile_pkg::CMP_W'(step_r);
  assign head       = cell_data[0];
  assign last_step  = (step_r == count_r - ile_pkg::CNT_W'(1));

  assign in_ready = (state_r == ile_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // row of cells, each tied to its neighbors
  for (genvar k = 0; k < ile_pkg::CAPACITY; k++) begin : g_cell
    ile_pkg::word_t prev_w;
    ile_pkg::word_t next_w;
    if (k == 0) begin : g_first
      assign prev_w = cell_data[k];
    end else begin : g_prev
      assign prev_w = cell_data[k-1];
    end
    if (k == ile_pkg::CAPACITY - 1) begin : g_last
      assign next_w = cell_data[k];
    end else begin : g_next
      assign next_w = cell_data[k+1];
    end
    ile_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .idx    (ile_pkg::CMP_W'(k)),
      .prev_d (prev_w),
      .next_d (next_w),
      .head_d (head),
      .data   (cell_data[k])
    );
  end

  // sequencer: next state, cell control and result
  always_comb begin
    state_nxt              = state_r;
    count_nxt              = count_r;
    len_nxt                = len_r;
    step_nxt               = step_r;
    op_nxt                 = op_r;
    pos_nxt                = pos_r;
    val_nxt                = val_r;
    saved_nxt              = saved_r;
    fnd_nxt                = fnd_r;
    fpos_nxt               = fpos_r;
    out_valid_nxt          = out_valid_r;
    out_read_value_nxt     = out_read_value_r;
    out_found_nxt          = out_found_r;
    out_found_position_nxt = out_found_position_r;
    out_list_length_nxt    = out_list_length_r;
    out_status_nxt         = out_status_r;
    ctrl.op                = ile_pkg::CELL_HOLD;
    ctrl.pos               = pos_r;
    ctrl.len               = ile_pkg::CMP_W'(len_r);
    ctrl.val               = in_word;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ile_pkg::S_IDLE: begin
        ctrl.pos = in_pos_ext;
        if (in_fire) begin
          out_valid_nxt          = 1'b1;
          out_read_value_nxt     = '0;
          out_found_nxt          = 1'b0;
          out_found_position_nxt = '0;
          out_status_nxt         = ile_pkg::ST_OK;
          op_nxt                 = in_action;
          pos_nxt                = in_pos_ext;
          val_nxt                = in_word;
          step_nxt               = '0;
          len_nxt                = count_r;
          fnd_nxt                = 1'b0;
          fpos_nxt               = '0;
          unique case (in_action) inside
            ile_pkg::ACT_INSERT: begin
              if (in_pos_ext > count_ext) begin
                out_status_nxt = ile_pkg::ST_BAD;
              end else if (count_r >= ile_pkg::CNT_W'(ile_pkg::CAPACITY)) begin
                out_status_nxt = ile_pkg::ST_FULL;
              end else begin
                ctrl.op   = ile_pkg::CELL_INSERT;
                count_nxt = count_r + ile_pkg::CNT_W'(1);
              end
            end
            ile_pkg::ACT_REMOVE: begin
              if (in_pos_ext >= count_ext) begin
                out_status_nxt = ile_pkg::ST_BAD;
              end else begin
                ctrl.op   = ile_pkg::CELL_REMOVE;
                count_nxt = count_r - ile_pkg::CNT_W'(1);
              end
            end
            ile_pkg::ACT_SEARCH: begin
              if (count_r != '0) begin
                out_valid_nxt = 1'b0;
                state_nxt     = ile_pkg::S_SCAN;
              end
            end
            ile_pkg::ACT_READ, ile_pkg::ACT_ERASE: begin
              if (in_pos_ext >= count_ext) begin
                out_status_nxt = ile_pkg::ST_BAD;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = ile_pkg::S_SCAN;
              end
            end
            ile_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
          out_list_length_nxt = ile_pkg::LEN_W'(count_nxt);
        end
      end

      // one full turn of the ring, entry step at the head
      ile_pkg::S_SCAN: begin
        ctrl.op  = ile_pkg::CELL_ROTATE;
        step_nxt = step_r + ile_pkg::CNT_W'(1);
        if ((op_r == ile_pkg::ACT_SEARCH) && !fnd_r && (head == val_r)) begin
          fnd_nxt  = 1'b1;
          fpos_nxt = ile_pkg::FPOS_W'(step_r);
        end
        if (step_ext == pos_r) begin
          saved_nxt = head;
        end
        if (last_step) begin
          step_nxt = '0;
          if (op_r == ile_pkg::ACT_ERASE) begin
            state_nxt = ile_pkg::S_ERASE;
          end else begin
            state_nxt              = ile_pkg::S_IDLE;
            out_valid_nxt          = 1'b1;
            out_read_value_nxt     = (op_r == ile_pkg::ACT_READ) ?
                                     ile_pkg::VAL_W'(saved_nxt) : '0;
            out_found_nxt          = fnd_nxt;
            out_found_position_nxt = fpos_nxt;
            out_list_length_nxt    = ile_pkg::LEN_W'(count_r);
            out_status_nxt         = ile_pkg::ST_OK;
          end
        end
      end

      // compaction turn: matches leave the ring, the rest rotate to the back
      ile_pkg::S_ERASE: begin
        step_nxt = step_r + ile_pkg::CNT_W'(1);
        if (head == saved_r) begin
          ctrl.op = ile_pkg::CELL_DROP;
          len_nxt = len_r - ile_pkg::CNT_W'(1);
        end else begin
          ctrl.op = ile_pkg::CELL_ROTATE;
        end
        if (last_step) begin
          state_nxt              = ile_pkg::S_IDLE;
          count_nxt              = len_nxt;
          out_valid_nxt          = 1'b1;
          out_read_value_nxt     = '0;
          out_found_nxt          = 1'b0;
          out_found_position_nxt = '0;
          out_list_length_nxt    = ile_pkg::LEN_W'(len_nxt);
          out_status_nxt         = ile_pkg::ST_OK;
        end
      end

      default: begin
        state_nxt = ile_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ile_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    len_r                <= len_nxt;
    step_r               <= step_nxt;
    op_r                 <= op_nxt;
    pos_r                <= pos_nxt;
    val_r                <= val_nxt;
    saved_r              <= saved_nxt;
    fnd_r                <= fnd_nxt;
    fpos_r               <= fpos_nxt;
    out_read_value_r     <= out_read_value_nxt;
    out_found_r          <= out_found_nxt;
    out_found_position_r <= out_found_position_nxt;
    out_list_length_r    <= out_list_length_nxt;
    out_status_r         <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_read_value_r;
  assign out_found          = out_found_r;
  assign out_found_position = out_found_position_r;
  assign out_list_length    = out_list_length_r;
  assign out_status         = out_status_r;

  // length count never exceeds the row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
    else $error("list length beyond capacity");

  // no result is pending while a scan runs
  a_scan_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ile_pkg::S_SCAN || state_r == ile_pkg::S_ERASE) |-> !out_valid_r)
    else $error("result pending during scan");

  // scan step stays inside the list
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ile_pkg::S_SCAN || state_r == ile_pkg::S_ERASE) |-> step_r < count_r)
    else $error("scan step past list end");

  // compaction ring only shrinks
  a_ring_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ile_pkg::S_ERASE) |-> len_r <= count_r)
    else $error("erase ring longer than list");

  // an insert, remove or clear request answers on the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_action == ile_pkg::ACT_CLEAR || in_action == ile_pkg::ACT_INSERT
      || in_action == ile_pkg::ACT_REMOVE)) |=> out_valid_r && (state_r == ile_pkg::S_IDLE))
    else $error("missing result for single-cycle request");

endmodule

@@ dv/tb_indexed_list_engine.sv @@
`timescale 1ns / 1ps

module tb_indexed_list_engine;

  // codes the block does not define, they must leave the list alone
  localparam logic [ile_pkg::ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ile_pkg::ACT_W-1:0] ACT_RSVD7 = 3'd7;

  localparam int RANDOM_REQUESTS = 1825;
  localparam int BLOCK_LEN       = 125;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 2 * ile_pkg::CAPACITY + 20;
  localparam int LIMIT_CYCLES    = 1000000;

  localparam ile_pkg::word_t W_MAX  = 32'h7fff_ffff;
  localparam ile_pkg::word_t W_MIN  = 32'h8000_0000;
  localparam ile_pkg::word_t W_NEG1 = 32'hffff_ffff;

  typedef enum {MODE_MIXED, MODE_FILL, MODE_DRAIN} traffic_mode_t;

  typedef struct packed {
    logic [ile_pkg::VAL_W-1:0]    read_value;
    logic                         found;
    logic [ile_pkg::FPOS_W-1:0]   found_position;
    logic [ile_pkg::LEN_W-1:0]    list_length;
    logic [ile_pkg::STATUS_W-1:0] status;
  } list_result_t;

  // shadow of the list plus the queue of results still owed by the block
  class list_scoreboard;
    ile_pkg::word_t entries [ile_pkg::CAPACITY];
    int unsigned    count;
    list_result_t   owed_q [$];
    int unsigned    mismatches, checked, n_full, n_bad, n_found, n_multi_erase, peak_len;

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // apply one accepted request to the shadow list and queue its result
    function void note_request(logic [ile_pkg::ACT_W-1:0] act,
                               logic [ile_pkg::POS_W-1:0] pos, ile_pkg::word_t val);
      list_result_t   r;
      ile_pkg::word_t saved;
      int unsigned    j, kept;
      bit             hit;
      r = '0;
      case (act)
        ile_pkg::ACT_INSERT: begin
          if (pos > count) begin
            r.status = ile_pkg::ST_BAD;
          end else if (count >= ile_pkg::CAPACITY) begin
            r.status = ile_pkg::ST_FULL;
          end else begin
            for (j = count; j > pos; j--) entries[j] = entries[j-1];
            entries[pos] = val;
            count++;
          end
        end
        ile_pkg::ACT_REMOVE: begin
          if (pos >= count) begin
            r.status = ile_pkg::ST_BAD;
          end else begin
            for (j = pos; j + 1 < count; j++) entries[j] = entries[j+1];
            count--;
          end
        end
        ile_pkg::ACT_SEARCH: begin
          hit = 1'b0;
          for (j = 0; j < count && !hit; j++) begin
            if (entries[j] == val) begin
              hit = 1'b1;
              r.found = 1'b1;
              r.found_position = j[ile_pkg::FPOS_W-1:0];
            end
          end
        end
        ile_pkg::ACT_READ: begin
          if (pos >= count) r.status = ile_pkg::ST_BAD;
          else r.read_value = entries[pos];
        end
        ile_pkg::ACT_CLEAR: count = 0;
        ile_pkg::ACT_ERASE: begin
          if (pos >= count) begin
            r.status = ile_pkg::ST_BAD;
          end else begin
            saved = entries[pos];
            kept = 0;
            for (j = 0; j < count; j++) begin
              if (entries[j] != saved) begin
                entries[kept] = entries[j];
                kept++;
              end
            end
            if (count - kept > 1) n_multi_erase++;
            count = kept;
          end
        end
        default: ;
      endcase
      r.list_length = count[ile_pkg::LEN_W-1:0];
      if (r.status == ile_pkg::ST_FULL) n_full++;
      if (r.status == ile_pkg::ST_BAD) n_bad++;
      if (r.found) n_found++;
      if (count > peak_len) peak_len = count;
      owed_q.push_back(r);
    endfunction

    // compare one accepted result with the oldest owed one
    function void check_result(list_result_t got);
      list_result_t exp;
      bit           bad;
      checked++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with no request outstanding: value %0d len %0d status %0d",
                   $time, $signed(got.read_value), got.list_length, got.status);
        return;
      end
      exp = owed_q.pop_front();
      bad = (got.read_value !== exp.read_value) || (got.found !== exp.found) ||
            (got.found_position !== exp.found_position) ||
            (got.list_length !== exp.list_length) || (got.status !== exp.status);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result %0d mismatch", $time, checked);
          $display("  expected value %0d found %0b pos %0d len %0d status %0d",
                   $signed(exp.read_value), exp.found, exp.found_position,
                   exp.list_length, exp.status);
          $display("  actual   value %0d found %0b pos %0d len %0d status %0d",
                   $signed(got.read_value), got.found, got.found_position,
                   got.list_length, got.status);
        end
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic [ile_pkg::ACT_W-1:0]           in_action;
  logic [ile_pkg::POS_W-1:0]           in_position;
  logic signed [ile_pkg::VAL_W-1:0]    in_item_value;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [ile_pkg::VAL_W-1:0]    out_read_value;
  logic                                out_found;
  logic [ile_pkg::FPOS_W-1:0]          out_found_position;
  logic [ile_pkg::LEN_W-1:0]           out_list_length;
  logic [ile_pkg::STATUS_W-1:0]        out_status;

  list_scoreboard sb = new();
  traffic_mode_t  phase_mode;
  bit             quiet;
  logic           hold_off;
  int             n_sent;
  int             cycle_count;

  indexed_list_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_position       (in_position),
    .in_item_value     (in_item_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_found         (out_found),
    .out_found_position(out_found_position),
    .out_list_length   (out_list_length),
    .out_status        (out_status)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    list_result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.read_value     = out_read_value;
        got.found          = out_found;
        got.found_position = out_found_position;
        got.list_length    = out_list_length;
        got.status         = out_status;
        sb.check_result(got);
      end
      if (in_valid && in_ready)
        sb.note_request(in_action, in_position, in_item_value);
    end
  end

  // random request shaped by the current traffic mode and the list length
  function automatic void pick_request(output logic [ile_pkg::ACT_W-1:0] act,
                                       output logic [ile_pkg::POS_W-1:0] pos,
                                       output ile_pkg::word_t val);
    ile_pkg::word_t pool [8];
    int unsigned    n, r;
    n = sb.count;
    pool = '{32'd0, 32'd1, W_NEG1, 32'd2, W_MAX, W_MIN, 32'd7, 32'hffff_fff9};
    r = $urandom_range(0, 99);
    case (phase_mode)
      MODE_FILL:  act = (r < 90) ? ile_pkg::ACT_INSERT :
                        (r < 95) ? ile_pkg::ACT_SEARCH : ile_pkg::ACT_READ;
      MODE_DRAIN: act = (r < 40) ? ile_pkg::ACT_REMOVE :
                        (r < 70) ? ile_pkg::ACT_ERASE  :
                        (r < 85) ? ile_pkg::ACT_SEARCH : ile_pkg::ACT_READ;
      default:    act = (r < 35) ? ile_pkg::ACT_INSERT :
                        (r < 50) ? ile_pkg::ACT_REMOVE :
                        (r < 65) ? ile_pkg::ACT_SEARCH :
                        (r < 80) ? ile_pkg::ACT_READ   :
                        (r < 90) ? ile_pkg::ACT_ERASE  :
                        (r < 93) ? ile_pkg::ACT_CLEAR  :
                        (r < 96) ? ACT_RSVD6 : ACT_RSVD7;
    endcase
    // mostly legal positions, sometimes anything the field allows
    if ($urandom_range(0, 9) == 0) pos = ile_pkg::POS_W'($urandom_range(0, 127));
    else if (act == ile_pkg::ACT_INSERT) pos = ile_pkg::POS_W'($urandom_range(0, n));
    else if (n == 0) pos = '0;
    else pos = ile_pkg::POS_W'($urandom_range(0, n - 1));
    // small pool makes duplicates, list picks make search hits
    case ($urandom_range(0, 2))
      0:       val = pool[$urandom_range(0, 7)];
      1:       val = $urandom;
      default: val = (n > 0) ? sb.entries[$urandom_range(0, n - 1)] :
                     ile_pkg::word_t'($urandom);
    endcase
  endfunction

  // offer one request and wait for it to be taken
  task automatic drive_request(input bit pick, input logic [ile_pkg::ACT_W-1:0] act,
                               input logic [ile_pkg::POS_W-1:0] pos,
                               input ile_pkg::word_t val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (pick) pick_request(act, pos, val);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_position   <= pos;
    in_item_value <= val;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // result side: random wait per result, honors the long hold-off
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        while (!out_valid) @(negedge clk);
        repeat (gap - 1) @(negedge clk);
      end
      do begin
        @(negedge clk);
        out_ready <= !hold_off;
        @(posedge clk);
      end while (!(out_valid && out_ready));
    end
  end

  // one long stall of the result side so the engine backs up into the input
  initial begin : long_stall
    hold_off = 1'b0;
    wait (n_sent >= 600);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // request source
  initial begin : request_source
    int i;
    in_valid      = 1'b0;
    in_action     = ile_pkg::ACT_INSERT;
    in_position   = '0;
    in_item_value = '0;
    rst_n         = 1'b0;
    quiet         = 1'b0;
    phase_mode    = MODE_MIXED;
    n_sent        = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list: every positional action is rejected, search misses
    drive_request(0, ile_pkg::ACT_READ,   7'd0, 32'd0);
    drive_request(0, ile_pkg::ACT_REMOVE, 7'd0, 32'd0);
    drive_request(0, ile_pkg::ACT_ERASE,  7'd0, 32'd0);
    drive_request(0, ile_pkg::ACT_SEARCH, 7'd0, 32'd0);
    drive_request(0, ile_pkg::ACT_INSERT, 7'd1, 32'd5);
    // build [-1, 0, max, min, -1] through end, front and middle inserts
    drive_request(0, ile_pkg::ACT_INSERT, 7'd0, W_MAX);
    drive_request(0, ile_pkg::ACT_INSERT, 7'd1, W_MIN);
    drive_request(0, ile_pkg::ACT_INSERT, 7'd0, W_NEG1);
    drive_request(0, ile_pkg::ACT_INSERT, 7'd1, 32'd0);
    drive_request(0, ile_pkg::ACT_INSERT, 7'd4, W_NEG1);
    // search hits on first copy, hit in the middle, miss
    drive_request(0, ile_pkg::ACT_SEARCH, 7'd127, W_NEG1);
    drive_request(0, ile_pkg::ACT_SEARCH, 7'd0, W_MIN);
    drive_request(0, ile_pkg::ACT_SEARCH, 7'd0, 32'd5);
    // read last entry, at the end, far past the end
    drive_request(0, ile_pkg::ACT_READ, 7'd4, 32'd0);
    drive_request(0, ile_pkg::ACT_READ, 7'd5, 32'd0);
    drive_request(0, ile_pkg::ACT_READ, 7'd127, 32'd0);
    // erase both copies of -1, then remove front and last
    drive_request(0, ile_pkg::ACT_ERASE,  7'd4, 32'd0);
    drive_request(0, ile_pkg::ACT_REMOVE, 7'd0, 32'd0);
    drive_request(0, ile_pkg::ACT_REMOVE, 7'd1, 32'd0);
    // undefined actions, insert far past the end, clear
    drive_request(0, ACT_RSVD6,           7'd127, W_NEG1);
    drive_request(0, ACT_RSVD7,           7'd64,  W_MIN);
    drive_request(0, ile_pkg::ACT_INSERT, 7'd127, 32'd3);
    drive_request(0, ile_pkg::ACT_CLEAR,  7'd0,   32'd0);
    // erase of a single entry empties the list
    drive_request(0, ile_pkg::ACT_INSERT, 7'd0, 32'd1);
    drive_request(0, ile_pkg::ACT_ERASE,  7'd0, 32'd0);

    // random traffic in blocks: fill, mix, drain, mix; some blocks with no idling
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % BLOCK_LEN == 0) begin
        case ((i / BLOCK_LEN) % 4)
          0:       phase_mode = MODE_FILL;
          2:       phase_mode = MODE_DRAIN;
          default: phase_mode = MODE_MIXED;
        endcase
        quiet = ((i / BLOCK_LEN) % 5 == 3);
      end
      drive_request(1, ile_pkg::ACT_INSERT, '0, '0);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;

    // wait for the last results, then let the engine settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked, longest list %0d of %0d",
             n_sent, sb.checked, sb.peak_len, ile_pkg::CAPACITY);
    $display("full rejects %0d, bad positions %0d, search hits %0d, multi-copy erases %0d",
             sb.n_full, sb.n_bad, sb.n_found, sb.n_multi_erase);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
